>>> design/lesf_pkg.sv
// shared types, constants and helpers for the largest empty square finder
// no dependencies

package lesf_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW      = 10;
  localparam int unsigned RowW      = 10;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CodeW     = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMPTY_CHAR    = 2'd0,
    CFG_OBSTACLE_CHAR = 2'd1,
    CFG_MAP_WIDTH     = 2'd2,
    CFG_MAP_HEIGHT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            blocked;
    logic            bad;
    logic            first;
    logic            last_col;
    logic            last_map;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } item_t;

  // last index of a row or column after clamping the size to 1..max
  function automatic logic [ColW-1:0] last_index(logic [CfgDataW-1:0] size,
                                                 logic [CfgDataW-1:0] max_size);
    logic [CfgDataW-1:0] clamped;
    begin
      if (size == '0) begin
        clamped = CfgDataW'(1);
      end else if (size > max_size) begin
        clamped = max_size;
      end else begin
        clamped = size;
      end
      last_index = ColW'(clamped - CfgDataW'(1));
    end
  endfunction

endpackage

>>> design/lesf_intf.sv
// channel interfaces for cells, results and configuration writes
// depends on lesf_pkg

interface lesf_cell_if;
  logic                         valid;
  logic                         ready;
  logic [lesf_pkg::CharW-1:0]   cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink   (input valid, input cell_char, output ready);
endinterface

interface lesf_result_if;
  logic                         valid;
  logic                         ready;
  logic [lesf_pkg::SizeW-1:0]   square_size;
  logic [lesf_pkg::RowW-1:0]    square_row;
  logic [lesf_pkg::ColW-1:0]    square_col;
  logic                         bad_map;

  modport source (output valid, output square_size, output square_row,
                  output square_col, output bad_map, input ready);
  modport sink   (input valid, input square_size, input square_row,
                  input square_col, input bad_map, output ready);
endinterface

interface lesf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lesf_pkg::CfgIdxW-1:0]   index;
  logic [lesf_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/lesf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module lesf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lesf_front.sv
// front end: config registers, cell classification and map position tracking
// depends on lesf_pkg and lesf_intf

module lesf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  lesf_cell_if.sink          cell_i,
  lesf_cfg_if.sink           cfg_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output lesf_pkg::item_t    item_o,
  output logic               restart_o
);

  logic [lesf_pkg::CodeW-1:0]    empty_char_q;
  logic [lesf_pkg::CodeW-1:0]    obstacle_char_q;
  logic [lesf_pkg::CfgDataW-1:0] map_width_q;
  logic [lesf_pkg::CfgDataW-1:0] map_height_q;
  logic [lesf_pkg::ColW-1:0]     col_q, col_d;
  logic [lesf_pkg::RowW-1:0]     row_q, row_d;
  logic [lesf_pkg::ColW-1:0]     last_col_idx;
  logic [lesf_pkg::RowW-1:0]     last_row_idx;
  logic                          is_empty;
  logic                          is_obstacle;
  logic                          accept;
  logic                          cfg_fire;
  logic                          size_write;

  assign cfg_i.ready  = 1'b1;
  assign cell_i.ready = !queue_full_i;
  assign accept       = cell_i.valid && !queue_full_i;
  assign cfg_fire     = cfg_i.valid;

  assign size_write = cfg_fire &&
                      ((lesf_pkg::cfg_reg_e'(cfg_i.index) == lesf_pkg::CFG_MAP_WIDTH) ||
                       (lesf_pkg::cfg_reg_e'(cfg_i.index) == lesf_pkg::CFG_MAP_HEIGHT));
  assign restart_o  = size_write;

  assign last_col_idx = lesf_pkg::last_index(map_width_q,
                                             lesf_pkg::CfgDataW'(lesf_pkg::MaxWidth));
  assign last_row_idx = lesf_pkg::RowW'(lesf_pkg::last_index(map_height_q,
                                             lesf_pkg::CfgDataW'(lesf_pkg::MaxHeight)));

  assign is_empty    = cell_i.cell_char == {1'b0, empty_char_q};
  assign is_obstacle = cell_i.cell_char == {1'b0, obstacle_char_q};

  always_comb begin
    item_o.blocked  = is_obstacle || !is_empty;
    item_o.bad      = !is_empty && !is_obstacle;
    item_o.first    = (row_q == '0) || (col_q == '0);
    item_o.last_col = col_q == last_col_idx;
    item_o.last_map = (col_q == last_col_idx) && (row_q == last_row_idx);
    item_o.row      = row_q;
    item_o.col      = col_q;
  end

  assign push_o = accept;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (size_write) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (item_o.last_col) begin
        col_d = '0;
        row_d = item_o.last_map ? '0 : row_q + lesf_pkg::RowW'(1);
      end else begin
        col_d = col_q + lesf_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_char_q    <= lesf_pkg::CodeW'(46);
      obstacle_char_q <= lesf_pkg::CodeW'(111);
      map_width_q     <= lesf_pkg::CfgDataW'(1);
      map_height_q    <= lesf_pkg::CfgDataW'(1);
      col_q           <= '0;
      row_q           <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_fire) begin
        unique case (lesf_pkg::cfg_reg_e'(cfg_i.index))
          lesf_pkg::CFG_EMPTY_CHAR:    empty_char_q    <= cfg_i.data[lesf_pkg::CodeW-1:0];
          lesf_pkg::CFG_OBSTACLE_CHAR: obstacle_char_q <= cfg_i.data[lesf_pkg::CodeW-1:0];
          lesf_pkg::CFG_MAP_WIDTH:     map_width_q     <= cfg_i.data;
          lesf_pkg::CFG_MAP_HEIGHT:    map_height_q    <= cfg_i.data;
          default:                     map_height_q    <= map_height_q;
        endcase
      end
    end
  end

endmodule

>>> design/lesf_queue.sv
// short flip-flop fifo of classified cells between front and back
// depends on lesf_pkg

module lesf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lesf_pkg::item_t    item_i,
  output logic               full_o,
  input  logic               pop_i,
  output lesf_pkg::item_t    head_o,
  output logic               valid_o
);

  lesf_pkg::item_t                  mem_q [lesf_pkg::QueueDepth];
  logic [lesf_pkg::QueuePtrW-1:0]   wr_ptr_q;
  logic [lesf_pkg::QueuePtrW-1:0]   rd_ptr_q;
  logic [lesf_pkg::QueuePtrW:0]     count_q;

  assign full_o  = count_q == (lesf_pkg::QueuePtrW+1)'(lesf_pkg::QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + lesf_pkg::QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + lesf_pkg::QueuePtrW'(1);
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + (lesf_pkg::QueuePtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (lesf_pkg::QueuePtrW+1)'(1);
      end
    end
  end

endmodule

>>> design/lesf_back.sv
// back end: line buffer lookup, square size update, best tracking, result register
// depends on lesf_pkg, lesf_intf and lesf_ram

module lesf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  lesf_pkg::item_t    head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  lesf_result_if.source      result_o
);

  logic                          c_valid_q;
  lesf_pkg::item_t               c_item_q;
  logic                          fwd_q;
  logic [lesf_pkg::SizeW-1:0]    fwd_val_q;
  logic [lesf_pkg::SizeW-1:0]    left_q;
  logic [lesf_pkg::SizeW-1:0]    diag_q;
  logic [lesf_pkg::SizeW-1:0]    best_size_q;
  logic [lesf_pkg::RowW-1:0]     best_row_q;
  logic [lesf_pkg::ColW-1:0]     best_col_q;
  logic                          bad_q;
  logic                          out_valid_q;
  logic [lesf_pkg::SizeW-1:0]    out_size_q;
  logic [lesf_pkg::RowW-1:0]     out_row_q;
  logic [lesf_pkg::ColW-1:0]     out_col_q;
  logic                          out_bad_q;

  logic [lesf_pkg::SizeW-1:0]    ram_rdata;
  logic [lesf_pkg::SizeW-1:0]    up;
  logic [lesf_pkg::SizeW-1:0]    min_val;
  logic [lesf_pkg::SizeW-1:0]    cell_size;
  logic [lesf_pkg::SizeW-1:0]    top_row;
  logic [lesf_pkg::SizeW-1:0]    top_col;
  logic                          better;
  logic [lesf_pkg::SizeW-1:0]    nb_size;
  logic [lesf_pkg::RowW-1:0]     nb_row;
  logic [lesf_pkg::ColW-1:0]     nb_col;
  logic                          stall;
  logic                          c_fire;
  logic                          pop;

  assign stall  = c_valid_q && c_item_q.last_map && out_valid_q && !result_o.ready;
  assign c_fire = c_valid_q && !stall;
  assign pop    = head_valid_i && !stall;
  assign pop_o  = pop;

  lesf_ram #(
    .Width (lesf_pkg::SizeW),
    .Depth (lesf_pkg::MaxWidth)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (c_fire),
    .waddr_i (c_item_q.col),
    .wdata_i (cell_size),
    .re_i    (pop),
    .raddr_i (head_i.col),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    up      = fwd_q ? fwd_val_q : ram_rdata;
    min_val = up;
    if (diag_q < min_val) begin
      min_val = diag_q;
    end
    if (left_q < min_val) begin
      min_val = left_q;
    end
    priority if (c_item_q.blocked) begin
      cell_size = '0;
    end else if (c_item_q.first) begin
      cell_size = lesf_pkg::SizeW'(1);
    end else begin
      cell_size = min_val + lesf_pkg::SizeW'(1);
    end
    top_row = {1'b0, c_item_q.row} + lesf_pkg::SizeW'(1) - cell_size;
    top_col = {1'b0, c_item_q.col} + lesf_pkg::SizeW'(1) - cell_size;
    better  = cell_size > best_size_q;
    nb_size = better ? cell_size : best_size_q;
    nb_row  = better ? top_row[lesf_pkg::RowW-1:0] : best_row_q;
    nb_col  = better ? top_col[lesf_pkg::ColW-1:0] : best_col_q;
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      c_item_q  <= head_i;
      fwd_val_q <= cell_size;
    end
    if (c_fire && c_item_q.last_map) begin
      out_size_q <= nb_size;
      out_row_q  <= nb_row;
      out_col_q  <= nb_col;
      out_bad_q  <= bad_q || c_item_q.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!stall) begin
        c_valid_q <= pop;
        // same column written by the cell ahead in this cycle
        fwd_q     <= pop && c_fire && (head_i.col == c_item_q.col);
      end
      if (restart_i) begin
        left_q      <= '0;
        diag_q      <= '0;
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
        bad_q       <= 1'b0;
      end else if (c_fire) begin
        if (c_item_q.last_col) begin
          left_q <= '0;
          diag_q <= '0;
        end else begin
          left_q <= cell_size;
          diag_q <= up;
        end
        if (c_item_q.last_map) begin
          best_size_q <= '0;
          best_row_q  <= '0;
          best_col_q  <= '0;
          bad_q       <= 1'b0;
        end else begin
          best_size_q <= nb_size;
          best_row_q  <= nb_row;
          best_col_q  <= nb_col;
          bad_q       <= bad_q || c_item_q.bad;
        end
      end
      if (c_fire && c_item_q.last_map) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.square_size = out_size_q;
  assign result_o.square_row  = out_row_q;
  assign result_o.square_col  = out_col_q;
  assign result_o.bad_map     = out_bad_q;

`ifndef SYNTHESIS
  a_end_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_fire && c_item_q.last_map) |=> out_valid_q)
    else $error("map end did not load the result register");

  a_end_clears_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_fire && c_item_q.last_map && !restart_i) |=> (best_size_q == '0) && !bad_q)
    else $error("best square not cleared after map end");

  a_stall_holds_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> c_valid_q && c_item_q.last_map)
    else $error("stalled cell lost in compute stage");
`endif

endmodule

>>> design/largest_empty_square_finder_top.sv
// largest empty square finder, top level
// result path: last cell goes through queue, compute stage and result register
// throughput: one cell per cycle, set by the single line buffer read per cell
// and the size update; a held result stalls the next map only at its last cell
// reset: rst_ni asynchronous active low; config returns to defaults, line buffer
// contents are left as is; only a map's first row reads them unwritten, unused

module largest_empty_square_finder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  lesf_cell_if.sink      cell_i,
  lesf_cfg_if.sink       cfg_i,
  lesf_result_if.source  result_o
);

  logic              push;
  lesf_pkg::item_t   front_item;
  logic              restart;
  logic              queue_full;
  lesf_pkg::item_t   head;
  logic              head_valid;
  logic              pop;

  lesf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_i       (cell_i),
    .cfg_i        (cfg_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item),
    .restart_o    (restart)
  );

  lesf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid)
  );

  lesf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule
